/* design/ntsc_drop_frame_timecode_converter_defines.svh */
// Assertion macros for the drop-frame timecode converter.
`ifndef NTSC_DROP_FRAME_TIMECODE_CONVERTER_DEFINES_SVH
`define NTSC_DROP_FRAME_TIMECODE_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define NDF_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low.
`define NDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ntscdf_pkg.sv */
// Constants for the NTSC drop-frame timecode converter.
package ntscdf_pkg;

	// Time field width and pipeline depth
	localparam int TIME_BITS  = 48;
	localparam int NUM_STAGES = 22;
	localparam int US_BITS    = 38;

	// Command codes
	localparam logic CMD_TIME_TO_TC = 1'b0;
	localparam logic CMD_TC_TO_TIME = 1'b1;

	// One frame is 100100/3 us, so frame = floor(3t / 100100)
	localparam logic [16:0] US_PER_3FRAMES   = 17'd100100;
	localparam logic [15:0] US_PER_FRAME_INT = 16'd33366;

	// Drop-frame structure
	localparam logic [14:0] FR_PER_10MIN      = 15'd17982;
	localparam int          FR_PER_1MIN       = 1798;
	localparam int          DROP_PER_MIN      = 2;
	localparam int          DROP_MINS_PER_SEG = 9;

	// Nominal 30 fps timecode weights
	localparam logic [16:0] FR_PER_HOUR    = 17'd108000;
	localparam logic [10:0] FR_PER_MIN_NOM = 11'd1800;
	localparam logic [4:0]  FR_PER_SEC     = 5'd30;
	localparam int          HALF_FPS       = 15;
	localparam int          SEC_PER_MIN    = 60;
	localparam int          MIN_PER_HOUR   = 60;
	localparam int          SEC_PER_HOUR   = 3600;
	localparam int          HOUR_SUBDIV    = 3;

	// Floor reciprocals: estimate is exact or one low
	localparam logic [33:0] RECIP_US    = 34'((64'd1 << 50) / 64'd100100);
	localparam logic [19:0] RECIP_SEG   = 20'((64'd1 << 34) / 64'd17982);
	localparam logic [29:0] RECIP_15_HI = 30'((64'd1 << 33) / 64'd15);
	localparam logic [24:0] RECIP_15_LO = 25'((64'd1 << 28) / 64'd15);
	localparam logic [18:0] RECIP_225   = 19'((64'd1 << 26) / 64'd225);
	localparam logic [14:0] RECIP_3     = 15'((64'd1 << 16) / 64'd3);

	// Ceiling reciprocals: exact over the narrow operand range used
	localparam logic [11:0] RECIP_10_CEIL = 12'(((64'd1 << 15) + 64'd9) / 64'd10);
	localparam logic [23:0] RECIP_3_CEIL  = 24'(((64'd1 << 25) + 64'd2) / 64'd3);

endpackage

/* design/ntsc_drop_frame_timecode_converter.sv */
// Converts microsecond time to 29.97 fps drop-frame timecode (cmd 0) and
// timecode back to microseconds (cmd 1). Fully pipelined: one transaction
// may enter every clock while the output is not stalled. The depth is set
// by the chain of constant divisions (microseconds to frames, ten-minute
// segments, then frames, seconds, minutes and hours), each done as a
// reciprocal multiply, split into partial products for the wide operands,
// and a one-step remainder correction. Stalls collapse bubbles, so the
// input keeps accepting while any stage is empty.
`include "ntsc_drop_frame_timecode_converter_defines.svh"

module ntsc_drop_frame_timecode_converter
	import ntscdf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 cmd,
	input  logic [TIME_BITS-1:0] time_us,
	input  logic [4:0]           tc_frames,
	input  logic [5:0]           tc_seconds,
	input  logic [5:0]           tc_minutes,
	input  logic [4:0]           tc_hours,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [TIME_BITS-1:0] out_time_us,
	output logic [4:0]           out_frames,
	output logic [5:0]           out_seconds,
	output logic [5:0]           out_minutes,
	output logic [4:0]           out_hours
);

	// Pipeline control
	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES:0]   adv;

	// Stage 1
	logic                 cmd_s1;
	logic [TIME_BITS+1:0] x_s1;
	logic [10:0]          tmins_s1;
	logic [21:0]          base_s1;
	// Stage 2
	logic                 cmd_s2;
	logic [TIME_BITS+1:0] x_s2;
	logic [41:0]          pp_hh_s2, pp_hl_s2, pp_lh_s2, pp_ll_s2;
	logic [11:0]          drop_s2;
	logic [21:0]          base_s2;
	// Stage 3
	logic                 cmd_s3;
	logic [TIME_BITS+1:0] x_s3;
	logic [59:0]          pa_s3, pb_s3;
	logic [21:0]          fr_s3;
	// Stage 4
	logic                 cmd_s4;
	logic [17:0]          x_s4;
	logic [33:0]          qus_s4;
	logic [US_BITS-1:0]   p1_s4;
	logic [21:0]          third_s4;
	logic                 frnz_s4;
	// Stage 5
	logic                 cmd_s5;
	logic [17:0]          x_s5;
	logic [33:0]          qus_s5;
	logic [17:0]          qprod_s5;
	logic [US_BITS-1:0]   us_s5;
	// Stage 6
	logic                 cmd_s6;
	logic [33:0]          n_s6;
	logic [US_BITS-1:0]   us_s6;
	// Stage 7
	logic                 cmd_s7;
	logic [33:0]          n_s7;
	logic [36:0]          sp_h_s7, sp_l_s7;
	logic [US_BITS-1:0]   us_s7;
	// Stage 8
	logic                 cmd_s8;
	logic [33:0]          n_s8;
	logic [19:0]          seg_s8;
	logic [US_BITS-1:0]   us_s8;
	// Stage 9
	logic                 cmd_s9;
	logic [33:0]          n_s9;
	logic [19:0]          seg_s9;
	logic [15:0]          segp_s9;
	logic [US_BITS-1:0]   us_s9;
	// Stage 10
	logic                 cmd_s10;
	logic [33:0]          n_s10;
	logic [19:0]          seg_s10;
	logic [14:0]          rem_s10;
	logic [US_BITS-1:0]   us_s10;
	// Stage 11
	logic                 cmd_s11;
	logic [33:0]          n_s11;
	logic [24:0]          inc_s11;
	logic [US_BITS-1:0]   us_s11;
	// Stage 12
	logic                 cmd_s12;
	logic [33:0]          d_s12;
	logic [US_BITS-1:0]   us_s12;
	// Stage 13
	logic                 cmd_s13;
	logic [33:0]          d_s13;
	logic [46:0]          dp_h_s13, dp_l_s13;
	logic [US_BITS-1:0]   us_s13;
	// Stage 14
	logic                 cmd_s14;
	logic [5:0]           dlo_s14;
	logic [29:0]          q1_s14;
	logic [US_BITS-1:0]   us_s14;
	// Stage 15
	logic                 cmd_s15;
	logic [5:0]           dlo_s15;
	logic [29:0]          q1_s15;
	logic [4:0]           q1p_s15;
	logic [US_BITS-1:0]   us_s15;
	// Stage 16
	logic                 cmd_s16;
	logic [29:0]          q1_s16;
	logic [4:0]           frames_s16;
	logic [US_BITS-1:0]   us_s16;
	// Stage 17
	logic                 cmd_s17;
	logic [29:0]          q1_s17;
	logic [52:0]          mp_s17;
	logic [44:0]          hp_s17;
	logic [4:0]           frames_s17;
	logic [US_BITS-1:0]   us_s17;
	// Stage 18
	logic                 cmd_s18;
	logic [29:0]          q1_s18;
	logic [23:0]          q2_s18;
	logic [18:0]          q3_s18;
	logic [4:0]           frames_s18;
	logic [US_BITS-1:0]   us_s18;
	// Stage 19
	logic                 cmd_s19;
	logic [12:0]          q1_s19;
	logic [23:0]          q2_s19;
	logic [18:0]          q3_s19;
	logic [6:0]           sp_s19;
	logic [12:0]          hp_s19;
	logic [4:0]           frames_s19;
	logic [US_BITS-1:0]   us_s19;
	// Stage 20
	logic                 cmd_s20;
	logic [23:0]          q2_s20;
	logic [18:0]          q3_s20;
	logic [5:0]           sec_s20;
	logic [4:0]           frames_s20;
	logic [US_BITS-1:0]   us_s20;
	// Stage 21
	logic                 cmd_s21;
	logic [18:0]          q3_s21;
	logic [30:0]          vp_s21;
	logic [5:0]           min_s21;
	logic [5:0]           sec_s21;
	logic [4:0]           frames_s21;
	logic [US_BITS-1:0]   us_s21;
	// Stage 22 (output register)
	logic [TIME_BITS-1:0] time_s22;
	logic [4:0]           frames_s22;
	logic [5:0]           sec_s22;
	logic [5:0]           min_s22;
	logic [4:0]           hours_s22;

	// Combinational helpers
	logic [22:0] tprod;
	logic [84:0] us_sum;
	logic [46:0] twothird_prod;
	logic [35:0] qprod_full;
	logic [17:0] rus;
	logic [53:0] seg_sum;
	logic [30:0] segp_full;
	logic [15:0] rseg;
	logic        seg_ge;
	logic [3:0]  extra;
	logic [63:0] d_sum;
	logic [8:0]  q1p_full;
	logic [4:0]  rfr;
	logic        fr_ge;
	logic [12:0] sp_full;
	logic [24:0] hp_full;
	logic [6:0]  rs;
	logic        sec_ge;
	logic [12:0] rh;
	logic        hour_ge;
	logic [11:0] minp;
	logic [14:0] qv;
	logic [4:0]  qv3;
	logic [2:0]  rv;
	logic [2:0]  rv_fix;

	// Stage k moves when the output is not stalled or any stage from k onward is empty
	always_comb begin
		adv[NUM_STAGES] = !rsp_stall;
		for (int k = 0; k < NUM_STAGES; k++) begin
			adv[k] = !rsp_stall ||
				((vld_q | NUM_STAGES'((64'd1 << k) - 64'd1)) != {NUM_STAGES{1'b1}});
		end
	end

	assign req_stall = !adv[0];
	assign rsp_valid = vld_q[NUM_STAGES-1];

	// Valid bits travel with the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= req_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// S1: 3t, total minutes, nominal frame count
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			cmd_s1   <= cmd;
			x_s1     <= {2'b00, time_us} + {1'b0, time_us, 1'b0};
			tmins_s1 <= 11'(tc_hours) * 11'(MIN_PER_HOUR) + 11'(tc_minutes);
			base_s1  <= 22'(tc_hours) * 22'(FR_PER_HOUR)
				+ 22'(tc_minutes) * 22'(FR_PER_MIN_NOM)
				+ 22'(tc_seconds) * 22'(FR_PER_SEC) + 22'(tc_frames);
		end
	end

	// S2: partial products of 3t * (2^50 / 100100); dropped frame labels
	always_comb begin
		tprod = 23'(tmins_s1) * 23'(RECIP_10_CEIL);
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			cmd_s2   <= cmd_s1;
			x_s2     <= x_s1;
			pp_hh_s2 <= 42'(x_s1[49:25]) * 42'(RECIP_US[33:17]);
			pp_hl_s2 <= 42'(x_s1[49:25]) * 42'(RECIP_US[16:0]);
			pp_lh_s2 <= 42'(x_s1[24:0]) * 42'(RECIP_US[33:17]);
			pp_ll_s2 <= 42'(x_s1[24:0]) * 42'(RECIP_US[16:0]);
			drop_s2  <= {tmins_s1 - 11'(tprod[22:15]), 1'b0};
			base_s2  <= base_s1;
		end
	end

	// S3: pair up partial products; drop-frame count
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			cmd_s3 <= cmd_s2;
			x_s3   <= x_s2;
			pa_s3  <= 60'({pp_hh_s2, 17'b0}) + 60'(pp_hl_s2);
			pb_s3  <= 60'({pp_lh_s2, 17'b0}) + 60'(pp_ll_s2);
			fr_s3  <= base_s2 - 22'(drop_s2);
		end
	end

	// S4: frame estimate; frames * 100100 / 3 as integer and thirds parts
	always_comb begin
		us_sum        = {pa_s3, 25'b0} + 85'(pb_s3);
		twothird_prod = 47'({fr_s3, 1'b0}) * 47'(RECIP_3_CEIL);
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			cmd_s4   <= cmd_s3;
			x_s4     <= x_s3[17:0];
			qus_s4   <= us_sum[83:50];
			p1_s4    <= US_BITS'(fr_s3) * US_BITS'(US_PER_FRAME_INT);
			third_s4 <= twothird_prod[46:25];
			frnz_s4  <= fr_s3 != '0;
		end
	end

	// S5: low bits of estimate * 100100; microsecond result, +1 when nonzero
	always_comb begin
		qprod_full = 36'(qus_s4[17:0]) * 36'(US_PER_3FRAMES);
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			cmd_s5   <= cmd_s4;
			x_s5     <= x_s4;
			qus_s5   <= qus_s4;
			qprod_s5 <= qprod_full[17:0];
			us_s5    <= p1_s4 + US_BITS'(third_s4) + US_BITS'(frnz_s4);
		end
	end

	// S6: remainder stays below 2 * 100100, one correction step
	always_comb begin
		rus = x_s5 - qprod_s5;
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			cmd_s6 <= cmd_s5;
			n_s6   <= qus_s5 + 34'(rus >= 18'(US_PER_3FRAMES));
			us_s6  <= us_s5;
		end
	end

	// S7: partial products of frame * (2^34 / 17982)
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			cmd_s7  <= cmd_s6;
			n_s7    <= n_s6;
			sp_h_s7 <= 37'(n_s6[33:17]) * 37'(RECIP_SEG);
			sp_l_s7 <= 37'(n_s6[16:0]) * 37'(RECIP_SEG);
			us_s7   <= us_s6;
		end
	end

	// S8: ten-minute segment estimate
	always_comb begin
		seg_sum = {sp_h_s7, 17'b0} + 54'(sp_l_s7);
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			cmd_s8 <= cmd_s7;
			n_s8   <= n_s7;
			seg_s8 <= seg_sum[53:34];
			us_s8  <= us_s7;
		end
	end

	// S9: low bits of segment * 17982
	always_comb begin
		segp_full = 31'(seg_s8[15:0]) * 31'(FR_PER_10MIN);
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			cmd_s9  <= cmd_s8;
			n_s9    <= n_s8;
			seg_s9  <= seg_s8;
			segp_s9 <= segp_full[15:0];
			us_s9   <= us_s8;
		end
	end

	// S10: segment correction and frame within segment
	always_comb begin
		rseg   = n_s9[15:0] - segp_s9;
		seg_ge = rseg >= 16'(FR_PER_10MIN);
	end

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			cmd_s10 <= cmd_s9;
			n_s10   <= n_s9;
			seg_s10 <= seg_s9 + 20'(seg_ge);
			rem_s10 <= 15'(seg_ge ? rseg - 16'(FR_PER_10MIN) : rseg);
			us_s10  <= us_s9;
		end
	end

	// S11: dropped minutes inside the segment; the first minute of a segment drops nothing
	always_comb begin
		extra = '0;
		for (int k = 1; k <= DROP_MINS_PER_SEG; k++) begin
			if (rem_s10 >= 15'(FR_PER_1MIN * k + DROP_PER_MIN)) begin
				extra = extra + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			cmd_s11 <= cmd_s10;
			n_s11   <= n_s10;
			inc_s11 <= 25'(seg_s10) * 25'(DROP_PER_MIN * DROP_MINS_PER_SEG)
				+ 25'({extra, 1'b0});
			us_s11  <= us_s10;
		end
	end

	// S12: timecode label count
	always_ff @(posedge clk) begin
		if (adv[11]) begin
			cmd_s12 <= cmd_s11;
			d_s12   <= n_s11 + 34'(inc_s11);
			us_s12  <= us_s11;
		end
	end

	// S13: partial products of (label / 2) * (2^33 / 15)
	always_ff @(posedge clk) begin
		if (adv[12]) begin
			cmd_s13  <= cmd_s12;
			d_s13    <= d_s12;
			dp_h_s13 <= 47'(d_s12[33:18]) * 47'(RECIP_15_HI);
			dp_l_s13 <= 47'(d_s12[17:1]) * 47'(RECIP_15_HI);
			us_s13   <= us_s12;
		end
	end

	// S14: total seconds estimate
	always_comb begin
		d_sum = {dp_h_s13, 17'b0} + 64'(dp_l_s13);
	end

	always_ff @(posedge clk) begin
		if (adv[13]) begin
			cmd_s14 <= cmd_s13;
			dlo_s14 <= d_s13[5:0];
			q1_s14  <= d_sum[62:33];
			us_s14  <= us_s13;
		end
	end

	// S15: low bits of seconds * 15
	always_comb begin
		q1p_full = 9'(q1_s14[4:0]) * 9'(HALF_FPS);
	end

	always_ff @(posedge clk) begin
		if (adv[14]) begin
			cmd_s15 <= cmd_s14;
			dlo_s15 <= dlo_s14;
			q1_s15  <= q1_s14;
			q1p_s15 <= q1p_full[4:0];
			us_s15  <= us_s14;
		end
	end

	// S16: seconds correction; frames = 2 * (half-label mod 15) + lsb
	always_comb begin
		rfr   = dlo_s15[5:1] - q1p_s15;
		fr_ge = rfr >= 5'(HALF_FPS);
	end

	always_ff @(posedge clk) begin
		if (adv[15]) begin
			cmd_s16    <= cmd_s15;
			q1_s16     <= q1_s15 + 30'(fr_ge);
			frames_s16 <= {4'(fr_ge ? rfr - 5'(HALF_FPS) : rfr), dlo_s15[0]};
			us_s16     <= us_s15;
		end
	end

	// S17: minute and hour estimates, (s / 4) / 15 and (s / 16) / 225
	always_ff @(posedge clk) begin
		if (adv[16]) begin
			cmd_s17    <= cmd_s16;
			q1_s17     <= q1_s16;
			mp_s17     <= 53'(q1_s16[29:2]) * 53'(RECIP_15_LO);
			hp_s17     <= 45'(q1_s16[29:4]) * 45'(RECIP_225);
			frames_s17 <= frames_s16;
			us_s17     <= us_s16;
		end
	end

	// S18: take quotient bits
	always_ff @(posedge clk) begin
		if (adv[17]) begin
			cmd_s18    <= cmd_s17;
			q1_s18     <= q1_s17;
			q2_s18     <= mp_s17[51:28];
			q3_s18     <= hp_s17[44:26];
			frames_s18 <= frames_s17;
			us_s18     <= us_s17;
		end
	end

	// S19: low bits of minutes * 60 and hours * 3600
	always_comb begin
		sp_full = 13'(q2_s18[6:0]) * 13'(SEC_PER_MIN);
		hp_full = 25'(q3_s18[12:0]) * 25'(SEC_PER_HOUR);
	end

	always_ff @(posedge clk) begin
		if (adv[18]) begin
			cmd_s19    <= cmd_s18;
			q1_s19     <= q1_s18[12:0];
			q2_s19     <= q2_s18;
			q3_s19     <= q3_s18;
			sp_s19     <= sp_full[6:0];
			hp_s19     <= hp_full[12:0];
			frames_s19 <= frames_s18;
			us_s19     <= us_s18;
		end
	end

	// S20: minute and hour corrections, seconds field
	always_comb begin
		rs      = q1_s19[6:0] - sp_s19;
		sec_ge  = rs >= 7'(SEC_PER_MIN);
		rh      = q1_s19 - hp_s19;
		hour_ge = rh >= 13'(SEC_PER_HOUR);
	end

	always_ff @(posedge clk) begin
		if (adv[19]) begin
			cmd_s20    <= cmd_s19;
			q2_s20     <= q2_s19 + 24'(sec_ge);
			q3_s20     <= q3_s19 + 19'(hour_ge);
			sec_s20    <= 6'(sec_ge ? rs - 7'(SEC_PER_MIN) : rs);
			frames_s20 <= frames_s19;
			us_s20     <= us_s19;
		end
	end

	// S21: minutes field; hours mod 24 via (h / 8) mod 3
	always_comb begin
		minp = 12'(q3_s20[5:0]) * 12'(MIN_PER_HOUR);
	end

	always_ff @(posedge clk) begin
		if (adv[20]) begin
			cmd_s21    <= cmd_s20;
			q3_s21     <= q3_s20;
			vp_s21     <= 31'(q3_s20[18:3]) * 31'(RECIP_3);
			min_s21    <= q2_s20[5:0] - minp[5:0];
			sec_s21    <= sec_s20;
			frames_s21 <= frames_s20;
			us_s21     <= us_s20;
		end
	end

	// S22: hours field and per-command result select
	always_comb begin
		qv     = vp_s21[30:16];
		qv3    = 5'(qv[2:0]) * 5'(HOUR_SUBDIV);
		rv     = q3_s21[5:3] - qv3[2:0];
		rv_fix = (rv >= 3'(HOUR_SUBDIV)) ? rv - 3'(HOUR_SUBDIV) : rv;
	end

	always_ff @(posedge clk) begin
		if (adv[21]) begin
			if (cmd_s21 == CMD_TC_TO_TIME) begin
				time_s22   <= TIME_BITS'(us_s21);
				frames_s22 <= '0;
				sec_s22    <= '0;
				min_s22    <= '0;
				hours_s22  <= '0;
			end else begin
				time_s22   <= '0;
				frames_s22 <= frames_s21;
				sec_s22    <= sec_s21;
				min_s22    <= min_s21;
				hours_s22  <= {rv_fix[1:0], q3_s21[2:0]};
			end
		end
	end

	assign out_time_us = time_s22;
	assign out_frames  = frames_s22;
	assign out_seconds = sec_s22;
	assign out_minutes = min_s22;
	assign out_hours   = hours_s22;

	// Checks
	`NDF_ASSERT(a_stall_only_when_full, req_stall, &vld_q, "input stalled with a free stage")
	`NDF_ASSERT_NEXT(a_accept_fills_s1, req_valid && !req_stall, vld_q[0], "accepted transaction lost at stage 1")
	`NDF_ASSERT(a_seg_rem_range, vld_q[9], rem_s10 < FR_PER_10MIN, "segment remainder out of range")
	`NDF_ASSERT(a_tc_range, rsp_valid, (out_frames < 5'd30) && (out_seconds < 6'd60) && (out_minutes < 6'd60) && (out_hours < 5'd24), "timecode field out of range")
	`NDF_ASSERT(a_cmd_exclusive, rsp_valid && (out_time_us != '0), (out_frames == '0) && (out_seconds == '0) && (out_minutes == '0) && (out_hours == '0), "both result kinds nonzero")

endmodule
